// File: src/dq_pkg.sv
package dq_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned STATUS_W = 2;

  // Queue geometry shared by the core, its interfaces and the testbench.
  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_BACK  = 3'd0,
    MODE_PUSH_FRONT = 3'd1,
    MODE_POP_BACK   = 3'd2,
    MODE_POP_FRONT  = 3'd3,
    MODE_CLEAR      = 3'd4
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK         = 2'd0,
    STATUS_POP_EMPTY  = 2'd1,
    STATUS_PUSH_FULL  = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;  // capture the request payload
    logic exec;   // perform the operation and write the store
    logic rd;     // read the front and back entries
  } dq_cmd_t;

endpackage

// File: src/dq_req_if.sv
interface dq_req_if;
  import dq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);

endinterface

// File: src/dq_rsp_if.sv
interface dq_rsp_if;
  import dq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [DATA_W-1:0] front_value;
  logic signed [DATA_W-1:0] back_value;
  logic [CNT_W-1:0]         entry_count;

  modport source (output valid, output status, output front_value, output back_value,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input front_value, input back_value,
                  input entry_count, output ready);

endinterface

// File: src/dq_ram.sv
module dq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_a_i,
  input  logic [AddrW-1:0] raddr_b_i,
  output logic [Width-1:0] rdata_a_o,
  output logic [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

// File: src/dq_ctrl.sv
module dq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  output logic             rsp_valid_o,
  input  logic             rsp_ready_i,
  output dq_pkg::dq_cmd_t  cmd_o
);
  import dq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_READ = 4'b0100,
    S_RESP = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    rsp_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_READ;
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_RESP;
      end
      S_RESP: begin
        rsp_valid_o = 1'b1;
        if (rsp_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: src/dq_datapath.sv
module dq_datapath #(
  parameter int unsigned Capacity = 16,
  localparam int unsigned IdxW = $clog2(Capacity),
  localparam int unsigned CntW = $clog2(Capacity + 1)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  dq_pkg::dq_cmd_t                  cmd_i,
  input  logic [dq_pkg::MODE_W-1:0]        mode_i,
  input  logic signed [dq_pkg::DATA_W-1:0] value_i,
  output logic [dq_pkg::STATUS_W-1:0]      status_o,
  output logic signed [dq_pkg::DATA_W-1:0] front_value_o,
  output logic signed [dq_pkg::DATA_W-1:0] back_value_o,
  output logic [CntW-1:0]                  entry_count_o
);
  import dq_pkg::*;

  localparam int unsigned SumW = CntW + 1;

  logic [MODE_W-1:0]   mode_q;
  logic [DATA_W-1:0]   value_q;
  logic [IdxW-1:0]     head_q, head_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [STATUS_W-1:0] status_q, status_d;

  logic                we;
  logic [IdxW-1:0]     waddr;
  logic [IdxW-1:0]     head_dec, head_inc, tail_idx, back_idx;
  logic                full, empty;
  logic [DATA_W-1:0]   rdata_front, rdata_back;

  // Circular index: head plus an offset of at most the capacity, folded back once.
  function automatic logic [IdxW-1:0] wrap_add(logic [IdxW-1:0] base, logic [CntW-1:0] off);
    logic [SumW-1:0] sum;
    sum = SumW'(base) + SumW'(off);
    if (sum >= SumW'(Capacity)) begin
      sum = sum - SumW'(Capacity);
    end
    return sum[IdxW-1:0];
  endfunction

  assign full     = (count_q == CntW'(Capacity));
  assign empty    = (count_q == '0);
  assign head_dec = (head_q == '0) ? IdxW'(Capacity - 1) : head_q - IdxW'(1);
  assign head_inc = (head_q == IdxW'(Capacity - 1)) ? '0 : head_q + IdxW'(1);
  assign tail_idx = wrap_add(head_q, count_q);
  assign back_idx = empty ? head_q : wrap_add(head_q, count_q - CntW'(1));

  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    status_d = STATUS_OK;
    we       = 1'b0;
    waddr    = tail_idx;
    case (mode_q)
      MODE_PUSH_BACK: begin
        if (full) begin
          status_d = STATUS_PUSH_FULL;
        end else begin
          we      = 1'b1;
          count_d = count_q + CntW'(1);
        end
      end
      MODE_PUSH_FRONT: begin
        if (full) begin
          status_d = STATUS_PUSH_FULL;
        end else begin
          we      = 1'b1;
          waddr   = head_dec;
          head_d  = head_dec;
          count_d = count_q + CntW'(1);
        end
      end
      MODE_POP_BACK: begin
        if (empty) begin
          status_d = STATUS_POP_EMPTY;
        end else begin
          count_d = count_q - CntW'(1);
        end
      end
      MODE_POP_FRONT: begin
        if (empty) begin
          status_d = STATUS_POP_EMPTY;
        end else begin
          head_d  = head_inc;
          count_d = count_q - CntW'(1);
        end
      end
      MODE_CLEAR: begin
        head_d  = '0;
        count_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      mode_q  <= mode_i;
      value_q <= value_i;
    end
    if (cmd_i.exec) begin
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else if (cmd_i.exec) begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  dq_ram #(
    .Width (DATA_W),
    .Depth (Capacity)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (cmd_i.exec & we),
    .waddr_i   (waddr),
    .wdata_i   (value_q),
    .re_i      (cmd_i.rd),
    .raddr_a_i (head_q),
    .raddr_b_i (back_idx),
    .rdata_a_o (rdata_front),
    .rdata_b_o (rdata_back)
  );

  assign status_o      = status_q;
  assign front_value_o = empty ? '0 : $signed(rdata_front);
  assign back_value_o  = empty ? '0 : $signed(rdata_back);
  assign entry_count_o = count_q;

endmodule

// File: src/double_ended_queue_core.sv
// Sequence: the request is latched, the operation is applied to the store,
// and the new front and back entries are read before the result is offered.
// A new request is taken only after the result transfer completes; the
// store write is followed by the registered read of the front and back
// entries from the same RAM.
// Reset: head index and entry count clear asynchronously; the entry store
// is not cleared and holds undefined data until written.
module double_ended_queue_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  dq_req_if.sink    req_i,
  dq_rsp_if.source  rsp_o
);
  import dq_pkg::*;

  // Each request is handled alone. The controller walks it through four
  // steps: take the request, apply the operation to head, count and the
  // store, read the new front and back entries, then hold the result until
  // its transfer completes. The datapath keeps the queue state, so the
  // controller needs no status back from it.
  dq_cmd_t cmd;

  dq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  // The datapath holds the circular store, the head index and the count.
  // A push at the front moves the head back by one slot before writing; a
  // pop at the front moves it forward. Pushing on a full queue and popping
  // an empty one leave the state untouched and only report a status.
  dq_datapath #(
    .Capacity (CAPACITY)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .mode_i        (req_i.mode),
    .value_i       (req_i.value),
    .status_o      (rsp_o.status),
    .front_value_o (rsp_o.front_value),
    .back_value_o  (rsp_o.back_value),
    .entry_count_o (rsp_o.entry_count)
  );

endmodule

// File: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dq_pkg::*;

  // The shadow index wraps naturally at IDX_W bits because the capacity is a
  // power of two.

  // Extreme data values used by the directed part and mixed into the random part.
  localparam logic signed [DATA_W-1:0] VALUE_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] VALUE_MIN   = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VALUE_ZERO  = 32'sh0000_0000;
  localparam logic signed [DATA_W-1:0] VALUE_M_ONE = 32'shFFFF_FFFF;

  // Lowest and highest codes of the mode field that select no operation.
  localparam int unsigned MODE_SPARE_LO = int'(MODE_CLEAR) + 1;
  localparam int unsigned MODE_SPARE_HI = (1 << MODE_W) - 1;

  // The receiver's long hold-off, and the number of cycles without any
  // transfer after which the run is declared hung.
  localparam int unsigned RSP_HOLD_CYCLES = 150;
  localparam int unsigned WATCHDOG_LIMIT  = 1000;
  // A short settle after the last result catches any stray extra one.
  localparam int unsigned SETTLE_CYCLES   = 8;

  typedef struct {
    status_e                  status;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] back_value;
    logic [CNT_W-1:0]         entry_count;
  } dq_result_t;

  logic clk_i;
  logic rst_ni;

  dq_req_if req_if ();
  dq_rsp_if rsp_if ();

  double_ended_queue_core DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // Shadow copy of the queue: circular store, front slot and occupancy.
  logic signed [DATA_W-1:0] shadow_store [CAPACITY];
  logic [IDX_W-1:0]         shadow_head;
  logic [CNT_W-1:0]         shadow_count;

  // Results predicted at each request transfer, oldest first.
  dq_result_t pending_results[$];
  int unsigned mismatch_count;

  // Random gaps on both channels are enabled while this is set.
  bit gaps_on;
  // Set by the sender to ask the receiver for one long hold-off.
  bit rsp_hold_req;
  // Random stimulus leans toward pushes while filling and toward pops otherwise,
  // so the queue keeps swinging between empty and full.
  bit filling;

  // Clock and a single reset pulse at the start of the run.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Applies one operation to the shadow queue and returns the result the core
  // must report for it. Pops on empty and pushes on full leave the state alone;
  // the spare mode codes change nothing and just report the contents.
  function automatic dq_result_t apply_deque_op(input logic [MODE_W-1:0] op,
                                                input logic signed [DATA_W-1:0] data);
    dq_result_t       res;
    logic [IDX_W-1:0] slot;
    res.status = STATUS_OK;
    case (op)
      MODE_PUSH_BACK: begin
        if (shadow_count == CAPACITY) begin
          res.status = STATUS_PUSH_FULL;
        end else begin
          slot = shadow_head + IDX_W'(shadow_count);
          shadow_store[slot] = data;
          shadow_count++;
        end
      end
      MODE_PUSH_FRONT: begin
        if (shadow_count == CAPACITY) begin
          res.status = STATUS_PUSH_FULL;
        end else begin
          shadow_head--;
          shadow_store[shadow_head] = data;
          shadow_count++;
        end
      end
      MODE_POP_BACK: begin
        if (shadow_count == 0) res.status = STATUS_POP_EMPTY;
        else shadow_count--;
      end
      MODE_POP_FRONT: begin
        if (shadow_count == 0) begin
          res.status = STATUS_POP_EMPTY;
        end else begin
          shadow_head++;
          shadow_count--;
        end
      end
      MODE_CLEAR: begin
        shadow_head  = '0;
        shadow_count = '0;
      end
      default: ;
    endcase
    // An empty queue reports zero at both ends. Every occupied slot has been
    // written by a push, so no undefined store word is ever looked at.
    if (shadow_count == 0) begin
      res.front_value = '0;
      res.back_value  = '0;
    end else begin
      slot = shadow_head + IDX_W'(shadow_count - 1);
      res.front_value = shadow_store[shadow_head];
      res.back_value  = shadow_store[slot];
    end
    res.entry_count = shadow_count;
    return res;
  endfunction

  // Drives one request and holds it until the transfer completes. The call
  // always starts and ends in a rising-edge time step, so valid stays high
  // across back-to-back transfers with a single assignment per step.
  task automatic send_op(input logic [MODE_W-1:0] op, input logic signed [DATA_W-1:0] data);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.mode  <= op;
    req_if.value <= data;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    pending_results.insert(pending_results.size(), apply_deque_op(op, data));
  endtask

  // Lowers valid and waits until every predicted result has been received.
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [DATA_W-1:0] random_value();
    case ($urandom_range(0, 15))
      0:       return VALUE_MAX;
      1:       return VALUE_MIN;
      2:       return VALUE_ZERO;
      3:       return VALUE_M_ONE;
      default: return $urandom;
    endcase
  endfunction

  // Chooses the next operation from the current occupancy of the shadow queue.
  function automatic logic [MODE_W-1:0] random_mode();
    int unsigned roll;
    bit          push;
    roll = $urandom_range(0, 99);
    if (shadow_count == CAPACITY) filling = 1'b0;
    else if (shadow_count == 0) filling = 1'b1;
    else if ($urandom_range(0, 31) == 0) filling = ~filling;
    if (roll < 2) return MODE_CLEAR;
    if (roll < 4) return MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
    push = filling ? (roll < 72) : (roll < 32);
    if (push) return $urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
    return $urandom_range(0, 1) ? MODE_POP_BACK : MODE_POP_FRONT;
  endfunction

  // Pops on an empty queue, a clear with nothing held, and the spare mode
  // codes, which must leave the queue untouched whatever value comes along.
  task automatic test_empty_queue();
    int unsigned code;
    send_op(MODE_POP_BACK, VALUE_MAX);
    send_op(MODE_POP_FRONT, VALUE_MIN);
    send_op(MODE_CLEAR, VALUE_M_ONE);
    for (code = MODE_SPARE_LO; code <= MODE_SPARE_HI; code++) begin
      send_op(MODE_W'(code), $urandom);
    end
  endtask

  // Extreme values at both ends. The first push at the front wraps the head
  // index below slot zero.
  task automatic test_value_extremes();
    send_op(MODE_PUSH_FRONT, VALUE_MIN);
    send_op(MODE_PUSH_BACK, VALUE_MAX);
    send_op(MODE_PUSH_FRONT, VALUE_M_ONE);
    send_op(MODE_PUSH_BACK, VALUE_ZERO);
  endtask

  // Fills the queue from both ends, pushes once more at each end to see the
  // full status, then pops from both ends and clears.
  task automatic test_full_queue();
    bit at_back;
    at_back = 1'b1;
    while (shadow_count < CAPACITY) begin
      send_op(at_back ? MODE_PUSH_BACK : MODE_PUSH_FRONT, random_value());
      at_back = ~at_back;
    end
    send_op(MODE_PUSH_BACK, VALUE_MAX);
    send_op(MODE_PUSH_FRONT, VALUE_MIN);
    send_op(MODE_POP_BACK, $urandom);
    send_op(MODE_POP_FRONT, $urandom);
    send_op(MODE_CLEAR, $urandom);
  endtask

  task automatic test_random_ops(input int unsigned n_ops);
    repeat (n_ops) send_op(random_mode(), random_value());
  endtask

  // The receiver stops taking results for a long stretch while requests keep
  // coming, so the core holds its result and must stall the request side.
  task automatic test_output_backpressure();
    rsp_hold_req = 1'b1;
    test_random_ops(40);
  endtask

  // The sender goes quiet until the core has returned every result, then
  // restarts from an idle core.
  task automatic test_drain_restart();
    wait_drained();
    test_random_ops(50);
  endtask

  // Stimulus: directed cases first, then random traffic with gaps, the two
  // pressure cases, and a final stretch with both sides running flat out.
  initial begin
    req_if.valid <= 1'b0;
    req_if.mode  <= MODE_PUSH_BACK;
    req_if.value <= '0;
    shadow_head    = '0;
    shadow_count   = '0;
    mismatch_count = 0;
    gaps_on        = 1'b1;
    rsp_hold_req   = 1'b0;
    filling        = 1'b1;
    foreach (shadow_store[i]) shadow_store[i] = '0;
    @(posedge rst_ni);
    @(posedge clk_i);

    test_empty_queue();
    test_value_extremes();
    test_full_queue();
    test_random_ops(1200);
    test_output_backpressure();
    test_drain_restart();
    gaps_on = 1'b0;
    test_random_ops(430);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Result side ready: random stall bursts while gaps are enabled, one long
  // hold-off on request, and ready held high otherwise.
  initial begin
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rsp_hold_req) begin
        rsp_hold_req = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (RSP_HOLD_CYCLES) @(posedge clk_i);
        rsp_if.ready <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Every result transfer is checked against the oldest prediction. Signals are
  // sampled in the active region right after the edge, which still holds the
  // values that were present at the edge.
  always @(posedge clk_i) begin
    dq_result_t want;
    if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no request waiting for it");
        mismatch_count++;
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (rsp_if.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, rsp_if.status);
          mismatch_count++;
        end
        if (rsp_if.front_value !== want.front_value) begin
          $error("front_value: expected %0d, actual %0d",
                 want.front_value, rsp_if.front_value);
          mismatch_count++;
        end
        if (rsp_if.back_value !== want.back_value) begin
          $error("back_value: expected %0d, actual %0d",
                 want.back_value, rsp_if.back_value);
          mismatch_count++;
        end
        if (rsp_if.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, actual %0d",
                 want.entry_count, rsp_if.entry_count);
          mismatch_count++;
        end
      end
    end
  end

  // Hang detection: the count restarts at every transfer on either channel.
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

endmodule
